// ----- design/assert_macros.svh -----
// assertion macros used by the core design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every cycle outside reset
`define OBSH_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked during reset as well
`define OBSH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/obsh_pkg.sv -----
// types, constants and reset values of the obstacle stop detector
package obsh_pkg;

   localparam int DIST_W      = 16;
   localparam int RUN_W       = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int EVENT_W     = 2;

   localparam logic [DIST_W-1:0] STOP_DIST_RST  = DIST_W'(260);
   localparam logic [DIST_W-1:0] CLEAR_DIST_RST = DIST_W'(360);
   localparam logic [DIST_W-1:0] HARD_DIST_RST  = DIST_W'(160);
   localparam logic [RUN_W-1:0]  STOP_RUN_RST   = RUN_W'(2);
   localparam logic [RUN_W-1:0]  CLEAR_RUN_RST  = RUN_W'(4);

   localparam logic [DIST_W:0]   CLEAR_MARGIN   = (DIST_W+1)'(80);
   localparam logic [RUN_W-1:0]  RUN_MAX        = {RUN_W{1'b1}};

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STOP_DIST     = 3'd0,
      CSR_CLEAR_DIST    = 3'd1,
      CSR_HARD_DIST     = 3'd2,
      CSR_STOP_SAMPLES  = 3'd3,
      CSR_CLEAR_SAMPLES = 3'd4
   } csr_index_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE  = 2'd0,
      EV_ENTER = 2'd1,
      EV_CLEAR = 2'd2
   } change_event_type;

   // effective thresholds after the register corrections
   typedef struct packed {
      logic [DIST_W-1:0] stop_eff;
      logic [DIST_W-1:0] clear_eff;
      logic [DIST_W-1:0] hard_eff;
      logic [RUN_W-1:0]  need_stop;
      logic [RUN_W-1:0]  need_clear;
   } thresh_type;

   typedef struct packed {
      logic [DIST_W-1:0] median;
      logic [DIST_W-1:0] smooth;
   } filt_type;

   typedef struct packed {
      logic             blocked_q;
      logic             blocked;
      change_event_type change_event;
   } hyst_status_type;

endpackage

// ----- design/obsh_ifs.sv -----
// valid/ready channels for distance samples and detector results
interface obsh_req_if;
   import obsh_pkg::*;
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] raw_distance;

   modport source (output valid, output raw_distance, input ready);
   modport sink   (input valid, input raw_distance, output ready);
endinterface

interface obsh_rsp_if;
   import obsh_pkg::*;
   logic               valid;
   logic               ready;
   logic [DIST_W-1:0]  raw_echo;
   logic [DIST_W-1:0]  median_distance;
   logic [DIST_W-1:0]  filtered_distance;
   logic               sample_valid;
   logic               is_blocked;
   logic [EVENT_W-1:0] change_event;

   modport source (output valid, output raw_echo, output median_distance,
                   output filtered_distance, output sample_valid, output is_blocked,
                   output change_event, input ready);
   modport sink   (input valid, input raw_echo, input median_distance,
                   input filtered_distance, input sample_valid, input is_blocked,
                   input change_event, output ready);
endinterface

// ----- design/obsh_csr.sv -----
// configuration registers and effective threshold derivation
module obsh_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [obsh_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [obsh_pkg::DIST_W-1:0]       csr_wdata,
   output obsh_pkg::thresh_type              thresh
);
   import obsh_pkg::*;

   logic [DIST_W-1:0] stop_dist_ff, clear_dist_ff, hard_dist_ff;
   logic [RUN_W-1:0]  stop_samples_ff, clear_samples_ff;
   logic [DIST_W:0]   clear_fallback;

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_dist_ff     <= STOP_DIST_RST;
         clear_dist_ff    <= CLEAR_DIST_RST;
         hard_dist_ff     <= HARD_DIST_RST;
         stop_samples_ff  <= STOP_RUN_RST;
         clear_samples_ff <= CLEAR_RUN_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_STOP_DIST:     stop_dist_ff     <= csr_wdata;
            CSR_CLEAR_DIST:    clear_dist_ff    <= csr_wdata;
            CSR_HARD_DIST:     hard_dist_ff     <= csr_wdata;
            CSR_STOP_SAMPLES:  stop_samples_ff  <= csr_wdata[RUN_W-1:0];
            CSR_CLEAR_SAMPLES: clear_samples_ff <= csr_wdata[RUN_W-1:0];
            default: ;
         endcase
      end
   end

   assign clear_fallback = {1'b0, stop_dist_ff} + CLEAR_MARGIN;

   always_comb begin
      thresh.stop_eff = stop_dist_ff;
      // fallback release distance saturates at full scale
      if (clear_dist_ff > stop_dist_ff) begin
         thresh.clear_eff = clear_dist_ff;
      end else if (clear_fallback[DIST_W]) begin
         thresh.clear_eff = {DIST_W{1'b1}};
      end else begin
         thresh.clear_eff = clear_fallback[DIST_W-1:0];
      end
      if (hard_dist_ff < stop_dist_ff) begin
         thresh.hard_eff = hard_dist_ff;
      end else begin
         thresh.hard_eff = stop_dist_ff >> 1;
      end
      thresh.need_stop  = (stop_samples_ff == '0) ? RUN_W'(1) : stop_samples_ff;
      thresh.need_clear = (clear_samples_ff == '0) ? RUN_W'(1) : clear_samples_ff;
   end
endmodule

// ----- design/obsh_filter.sv -----
// three-entry median prefilter and low-pass smoother
module obsh_filter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        update,
   input  logic [obsh_pkg::DIST_W-1:0] raw,
   output obsh_pkg::filt_type          filt
);
   import obsh_pkg::*;

   logic [DIST_W-1:0] ring_ff [3];
   logic [DIST_W-1:0] ring_in [3];
   logic [1:0]        pos_ff, pos_in;
   logic [1:0]        fill_ff, fill_in;
   logic [DIST_W-1:0] median_ff, median_in;
   logic [DIST_W-1:0] smooth_ff, smooth_in;
   logic              seeded_ff, seeded_in;
   logic [DIST_W:0]   pair_sum;
   logic [DIST_W+1:0] smooth_sum;
   logic [DIST_W-1:0] lo, hi, mid3;
   logic              sample_ok;

   assign sample_ok = (raw != '0);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ring_in[i] = (pos_ff == 2'(i)) ? raw : ring_ff[i];
      end
      pos_in  = (pos_ff == 2'd2) ? 2'd0 : pos_ff + 2'd1;
      fill_in = (fill_ff == 2'd3) ? fill_ff : fill_ff + 2'd1;

      pair_sum = {1'b0, ring_in[0]} + {1'b0, ring_in[1]};
      lo = (ring_in[0] < ring_in[1]) ? ring_in[0] : ring_in[1];
      hi = (ring_in[0] < ring_in[1]) ? ring_in[1] : ring_in[0];
      if (ring_in[2] <= lo) begin
         mid3 = lo;
      end else if (ring_in[2] >= hi) begin
         mid3 = hi;
      end else begin
         mid3 = ring_in[2];
      end

      case (fill_in)
         2'd1:    median_in = ring_in[0];
         2'd2:    median_in = pair_sum[DIST_W:1];
         default: median_in = mid3;
      endcase

      smooth_sum = {1'b0, smooth_ff, 1'b0} + {2'b00, smooth_ff} + {2'b00, median_in}
                   + (DIST_W+2)'(2);
      smooth_in  = seeded_ff ? smooth_sum[DIST_W+1:2] : median_in;
      seeded_in  = 1'b1;

      // an invalid sample leaves everything as it was
      if (!sample_ok) begin
         for (int i = 0; i < 3; i++) begin
            ring_in[i] = ring_ff[i];
         end
         pos_in    = pos_ff;
         fill_in   = fill_ff;
         median_in = median_ff;
         smooth_in = smooth_ff;
         seeded_in = seeded_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= 2'd0;
         fill_ff   <= 2'd0;
         median_ff <= '0;
         smooth_ff <= '0;
         seeded_ff <= 1'b0;
      end else if (update) begin
         pos_ff    <= pos_in;
         fill_ff   <= fill_in;
         median_ff <= median_in;
         smooth_ff <= smooth_in;
         seeded_ff <= seeded_in;
      end
   end

   // ring entries are only read once the fill count covers them
   always_ff @(posedge clock) begin
      if (update) begin
         for (int i = 0; i < 3; i++) begin
            ring_ff[i] <= ring_in[i];
         end
      end
   end

   assign filt.median = median_in;
   assign filt.smooth = smooth_in;
endmodule

// ----- design/obsh_hyst.sv -----
// hysteresis run counters and stop state
module obsh_hyst (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        update,
   input  logic [obsh_pkg::DIST_W-1:0] raw,
   input  obsh_pkg::filt_type          filt,
   input  obsh_pkg::thresh_type        thresh,
   output obsh_pkg::hyst_status_type   status
);
   import obsh_pkg::*;

   logic             blocked_ff, blocked_in;
   logic [RUN_W-1:0] near_ff, near_in;
   logic [RUN_W-1:0] clear_ff, clear_in;
   change_event_type ev;
   logic             hard_near, stable_near, stable_clear;

   assign hard_near    = (raw <= thresh.hard_eff);
   assign stable_near  = (filt.median <= thresh.stop_eff) || (filt.smooth <= thresh.stop_eff);
   assign stable_clear = (filt.median >= thresh.clear_eff) && (filt.smooth >= thresh.clear_eff);

   always_comb begin
      blocked_in = blocked_ff;
      near_in    = near_ff;
      clear_in   = clear_ff;
      ev         = EV_NONE;
      if (raw != '0) begin
         if (!blocked_ff) begin
            if (hard_near) begin
               near_in = thresh.need_stop;
            end else if (stable_near) begin
               near_in = (near_ff == RUN_MAX) ? near_ff : near_ff + RUN_W'(1);
            end else begin
               near_in = '0;
            end
            if (near_in >= thresh.need_stop) begin
               blocked_in = 1'b1;
               clear_in   = '0;
               ev         = EV_ENTER;
            end
         end else begin
            if (stable_clear) begin
               clear_in = (clear_ff == RUN_MAX) ? clear_ff : clear_ff + RUN_W'(1);
            end else begin
               clear_in = '0;
            end
            if (clear_in >= thresh.need_clear) begin
               blocked_in = 1'b0;
               near_in    = '0;
               ev         = EV_CLEAR;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blocked_ff <= 1'b0;
         near_ff    <= '0;
         clear_ff   <= '0;
      end else if (update) begin
         blocked_ff <= blocked_in;
         near_ff    <= near_in;
         clear_ff   <= clear_in;
      end
   end

   assign status.blocked_q    = blocked_ff;
   assign status.blocked      = blocked_in;
   assign status.change_event = ev;
endmodule

// ----- design/obstacle_stop_hysteresis_core.sv -----
// Obstacle stop detector: median-of-three prefilter, low-pass smoother, hysteresis.
//
// req_bus carries one raw distance per beat (zero marks an invalid reading);
// rsp_bus returns exactly one result beat per request beat, in order: the raw
// echo, the median and smoothed distances, a valid flag, the stop state and a
// change event (none, stop entered, stop cleared).
// csr_we/csr_index/csr_wdata write the five threshold and count registers;
// write them only while no beat is in flight.
// Each request beat is held in the input register, then the filter and
// hysteresis update in one pass into the output register. Throughput is one beat
// per cycle while rsp_bus does not stall, set by that single update pass on the
// input register.
// When rsp_bus stalls, the output register holds its beat and the input
// register still takes one more beat; req_bus.ready drops only when both hold.
// Synchronous reset clears all filter state except the ring entries, the stop
// state, the run counters and both stage valids, and loads the register defaults.
`include "assert_macros.svh"

module obstacle_stop_hysteresis_core (
   input  logic                              clock,
   input  logic                              reset,
   obsh_req_if.sink                          req_bus,
   obsh_rsp_if.source                        rsp_bus,
   input  logic                              csr_we,
   input  logic [obsh_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [obsh_pkg::DIST_W-1:0]       csr_wdata
);
   import obsh_pkg::*;

   logic              in_valid_ff;
   logic [DIST_W-1:0] in_raw_ff;
   logic              out_valid_ff;
   logic [DIST_W-1:0] out_raw_ff, out_median_ff, out_smooth_ff;
   logic              out_sample_ok_ff, out_blocked_ff;
   change_event_type  out_event_ff;
   logic              advance;
   thresh_type        thresh;
   filt_type          filt;
   hyst_status_type   status;

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   obsh_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .thresh    (thresh)
   );

   obsh_filter u_filter (
      .clock  (clock),
      .reset  (reset),
      .update (advance),
      .raw    (in_raw_ff),
      .filt   (filt)
   );

   obsh_hyst u_hyst (
      .clock  (clock),
      .reset  (reset),
      .update (advance),
      .raw    (in_raw_ff),
      .filt   (filt),
      .thresh (thresh),
      .status (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_raw_ff <= req_bus.raw_distance;
      end
      if (advance) begin
         out_raw_ff       <= in_raw_ff;
         out_median_ff    <= filt.median;
         out_smooth_ff    <= filt.smooth;
         out_sample_ok_ff <= (in_raw_ff != '0);
         out_blocked_ff   <= status.blocked;
         out_event_ff     <= status.change_event;
      end
   end

   assign rsp_bus.valid             = out_valid_ff;
   assign rsp_bus.raw_echo          = out_raw_ff;
   assign rsp_bus.median_distance   = out_median_ff;
   assign rsp_bus.filtered_distance = out_smooth_ff;
   assign rsp_bus.sample_valid      = out_sample_ok_ff;
   assign rsp_bus.is_blocked        = out_blocked_ff;
   assign rsp_bus.change_event      = out_event_ff;

   // a stalled response beat must not be overwritten
   `OBSH_ASSERT(a_no_overwrite, clock, reset, out_valid_ff && !rsp_bus.ready |-> !advance, "response overwritten while stalled")
   // an invalid sample never moves the stop state
   `OBSH_ASSERT(a_invalid_holds, clock, reset, advance && (in_raw_ff == '0) |-> (status.blocked == status.blocked_q), "invalid sample changed stop state")
   // events agree with the stop state transition
   `OBSH_ASSERT(a_enter_event, clock, reset, advance && (status.change_event == EV_ENTER) |-> status.blocked && !status.blocked_q, "enter event without entering stop")
   `OBSH_ASSERT(a_clear_event, clock, reset, advance && (status.change_event == EV_CLEAR) |=> !out_blocked_ff && out_valid_ff, "clear event without release")
endmodule
